// File: hw/rtl/avq_pkg.sv
// Shared types, constants and rounding helpers for the vector-alignment quaternion block.
// No dependencies.
package avq_pkg;

  localparam int IN_W  = 24;
  localparam int OUT_W = 18;

  typedef logic signed [IN_W-1:0]  vin_t;
  typedef logic signed [OUT_W-1:0] qout_t;

  // 1e-4 in Q1.30
  localparam logic [31:0] SIN_MIN_Q30 = 32'd107374;
  localparam logic signed [63:0] Q16_ONE = 64'sd65536;

  // Shift right by n, round to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned n);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic qout_t sat_q16(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > Q16_ONE) c = Q16_ONE;
    if (v < -Q16_ONE) c = -Q16_ONE;
    return qout_t'(c[OUT_W-1:0]);
  endfunction

endpackage

// File: hw/rtl/avq_isqrt.sv
// Pipelined integer square root, one result bit per register stage, several lanes.
// Carries a side payload and a valid bit alongside; no package dependency.
module avq_isqrt #(
  parameter int LANES = 1,
  parameter int IN_W  = 64,
  parameter int SW    = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             valid_i,
  input  logic [LANES-1:0][IN_W-1:0]       rad_i,
  input  logic [SW-1:0]                    side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][IN_W/2-1:0]     root_o,
  output logic [SW-1:0]                    side_o
);

  localparam int K  = IN_W / 2;
  localparam int RW = K + 2;

  logic [K-1:0]                   val_r;
  logic [SW-1:0]                  side_r   [K];
  logic [LANES-1:0][RW-1:0]       rem_r    [K];
  logic [LANES-1:0][RW-1:0]       rem_nxt  [K];
  logic [LANES-1:0][RW-1:0]       rem_in   [K];
  logic [LANES-1:0][K-1:0]        root_r   [K];
  logic [LANES-1:0][K-1:0]        root_nxt [K];
  logic [LANES-1:0][K-1:0]        root_in  [K];
  logic [LANES-1:0][IN_W-1:0]     rad_r    [K];
  logic [LANES-1:0][IN_W-1:0]     rad_nxt  [K];
  logic [LANES-1:0][IN_W-1:0]     rad_in   [K];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad_i;
    for (int k = 1; k < K; k++) begin
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
      rad_in[k]  = rad_r[k-1];
    end
  end

  always_comb begin
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    for (int k = 0; k < K; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rsh   = {rem_in[k][l][RW-3:0], rad_in[k][l][IN_W-1:IN_W-2]};
        trial = {root_in[k][l], 2'b01};
        if (rsh >= trial) begin
          rem_nxt[k][l]  = rsh - trial;
          root_nxt[k][l] = {root_in[k][l][K-2:0], 1'b1};
        end else begin
          rem_nxt[k][l]  = rsh;
          root_nxt[k][l] = {root_in[k][l][K-2:0], 1'b0};
        end
        rad_nxt[k][l] = {rad_in[k][l][IN_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[K-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < K; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
      for (int k = 1; k < K; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_o = val_r[K-1];
  assign root_o  = root_r[K-1];
  assign side_o  = side_r[K-1];

endmodule

// File: hw/rtl/avq_div.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes.
// Needs num < den * 2^QW. Carries a side payload and a valid bit; no package dependency.
module avq_div #(
  parameter int LANES = 1,
  parameter int NW    = 61,
  parameter int DW    = 31,
  parameter int QW    = 31,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [LANES-1:0][DW-1:0]     den_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][QW-1:0]     quo_o,
  output logic [SW-1:0]                side_o
);

  logic [QW-1:0]                val_r;
  logic [SW-1:0]                side_r  [QW];
  logic [LANES-1:0][DW-1:0]     rem_r   [QW];
  logic [LANES-1:0][DW-1:0]     rem_nxt [QW];
  logic [LANES-1:0][DW-1:0]     rem_in  [QW];
  logic [LANES-1:0][DW-1:0]     den_r   [QW];
  logic [LANES-1:0][DW-1:0]     den_in  [QW];
  logic [LANES-1:0][QW-1:0]     lo_r    [QW];
  logic [LANES-1:0][QW-1:0]     lo_nxt  [QW];
  logic [LANES-1:0][QW-1:0]     lo_in   [QW];
  logic [LANES-1:0][QW-1:0]     quo_r   [QW];
  logic [LANES-1:0][QW-1:0]     quo_nxt [QW];
  logic [LANES-1:0][QW-1:0]     quo_in  [QW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = DW'(num_i[l] >> QW);
      lo_in[0][l]  = num_i[l][QW-1:0];
    end
    quo_in[0] = '0;
    den_in[0] = den_i;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem_r[k-1];
      lo_in[k]  = lo_r[k-1];
      quo_in[k] = quo_r[k-1];
      den_in[k] = den_r[k-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic        qb;
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_in[k][l], lo_in[k][l][QW-1]};
        qb    = (trial >= {1'b0, den_in[k][l]});
        if (qb) begin
          rem_nxt[k][l] = DW'(trial - {1'b0, den_in[k][l]});
        end else begin
          rem_nxt[k][l] = DW'(trial);
        end
        lo_nxt[k][l]  = {lo_in[k][l][QW-2:0], 1'b0};
        quo_nxt[k][l] = {quo_in[k][l][QW-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= {val_r[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_in[k];
      end
      for (int k = 1; k < QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_o = val_r[QW-1];
  assign quo_o   = quo_r[QW-1];
  assign side_o  = side_r[QW-1];

endmodule

// File: hw/rtl/align_vectors_quaternion.sv
// Takes one request per cycle while in_stall is low. Cost is set by the
// three bit-per-stage square roots and two dividers in series.
// The whole pipeline advances while the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Depends on avq_pkg, avq_isqrt, avq_div.
module align_vectors_quaternion (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  avq_pkg::vin_t  in_target_x,
  input  avq_pkg::vin_t  in_target_y,
  input  avq_pkg::vin_t  in_target_z,
  input  avq_pkg::vin_t  in_source_x,
  input  avq_pkg::vin_t  in_source_y,
  input  avq_pkg::vin_t  in_source_z,
  output logic           out_valid,
  input  logic           out_stall,
  output avq_pkg::qout_t out_quat_w,
  output avq_pkg::qout_t out_quat_x,
  output avq_pkg::qout_t out_quat_y,
  output avq_pkg::qout_t out_quat_z,
  output logic           out_valid_res
);

  import avq_pkg::*;

  logic adv;
  logic [5:0][23:0] in_v;   // 0..2 source, 3..5 target

  // stage A: squares
  logic             a_val_r;
  logic [5:0][23:0] a_v_r;
  logic [5:0][46:0] a_sq_r, a_sq_nxt;
  // stage B: sums of squares
  logic             b_val_r;
  logic [5:0][23:0] b_v_r;
  logic [1:0][61:0] b_rad_r, b_rad_nxt;
  // input lengths
  logic             l1_val;
  logic [1:0][30:0] l1_len;
  logic [5:0][23:0] l1_v;
  // stage C: numerators
  logic             c_val_r, c_deg_r, c_deg_nxt;
  logic [5:0][60:0] c_num_r, c_num_nxt;
  logic [5:0][30:0] c_den_r, c_den_nxt;
  logic [5:0]       c_neg_r, c_neg_nxt;
  // unit vectors
  logic             q1_val;
  logic [5:0][30:0] q1;
  logic [6:0]       q1_side;
  // stage D: signed units, half vector
  logic             d_val_r, d_deg_r;
  logic [2:0][31:0] d_us_r, d_ut_r, d_us_nxt, d_ut_nxt;
  logic [2:0][32:0] d_h_r, d_h_nxt;
  // stage E: squares of h
  logic             e_val_r, e_deg_r;
  logic [2:0][31:0] e_us_r, e_ut_r;
  logic [2:0][32:0] e_h_r;
  logic [2:0][63:0] e_sq_r, e_sq_nxt;
  // stage F: sum
  logic             f_val_r, f_deg_r;
  logic [2:0][31:0] f_us_r, f_ut_r;
  logic [2:0][32:0] f_h_r;
  logic [0:0][63:0] f_rad_r;
  // half-vector length
  logic             l2_val, l2_deg;
  logic [0:0][31:0] l2_len;
  logic [291:0]     l2_side;
  logic [2:0][31:0] l2_us, l2_ut;
  logic [2:0][32:0] l2_h;
  // stage G: numerators for h
  logic             g_val_r, g_deg_r;
  logic [2:0][31:0] g_us_r, g_ut_r;
  logic [2:0][61:0] g_num_r, g_num_nxt;
  logic [2:0][31:0] g_den_r;
  logic [2:0]       g_hneg_r, g_hneg_nxt;
  // normalized h
  logic             q2_val, q2_deg;
  logic [2:0][30:0] q2;
  logic [195:0]     q2_side;
  logic [2:0][31:0] q2_us, q2_ut;
  logic [2:0]       q2_hneg;
  // stage H: products
  logic             h_val_r, h_deg_r;
  logic [2:0][31:0] h_us_r, h_ut_r;
  logic [2:0][63:0] h_pd_r, h_pd_nxt;
  logic [5:0][63:0] h_pc_r, h_pc_nxt;
  // stage I: dot and cross sums
  logic             i_val_r, i_deg_r;
  logic [2:0][31:0] i_us_r, i_ut_r;
  logic [63:0]      i_wdot_r;
  logic [2:0][63:0] i_cr_r;
  // stage J: rounding
  logic             j_val_r, j_deg_r;
  logic [2:0][31:0] j_us_r, j_ut_r;
  logic [20:0]      j_w_r;
  logic [2:0][32:0] j_c_r;
  // stage K: squares of c, products for us x c
  logic             k_val_r, k_deg_r;
  logic [2:0][31:0] k_ut_r;
  logic [20:0]      k_w_r;
  logic [2:0][32:0] k_c_r;
  logic [2:0][63:0] k_csq_r, k_csq_nxt;
  logic [5:0][63:0] k_dp_r, k_dp_nxt;
  // stage L
  logic             l_val_r, l_deg_r;
  logic [2:0][31:0] l_ut_r;
  logic [20:0]      l_w_r;
  logic [2:0][32:0] l_c_r;
  logic [63:0]      l_rad_r;
  logic [2:0][63:0] l_dr_r;
  // stage M
  logic             m_val_r, m_deg_r;
  logic [2:0][31:0] m_ut_r;
  logic [20:0]      m_w_r;
  logic [2:0][32:0] m_c_r;
  logic [63:0]      m_rad_r;
  logic [2:0][33:0] m_d_r;
  // stage N
  logic             n_val_r, n_deg_r;
  logic [20:0]      n_w_r;
  logic [2:0][32:0] n_c_r;
  logic [63:0]      n_rad_r;
  logic [2:0][63:0] n_sp_r, n_sp_nxt;
  // stage O
  logic             o_val_r, o_deg_r, o_neg_r;
  logic [20:0]      o_w_r;
  logic [2:0][32:0] o_c_r;
  logic [0:0][63:0] o_rad_r;
  // sine
  logic             l3_val, l3_deg, l3_neg;
  logic [0:0][31:0] l3_root;
  logic [121:0]     l3_side;
  logic [20:0]      l3_w;
  logic [2:0][32:0] l3_c;
  // output register
  logic             out_valid_r;
  qout_t            qw_r, qx_r, qy_r, qz_r, qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic             vres_r, vres_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_v = {in_target_z, in_target_y, in_target_x, in_source_z, in_source_y, in_source_x};

  always_comb begin
    logic [23:0] m;
    for (int i = 0; i < 6; i++) begin
      m = in_v[i][23] ? (~in_v[i] + 24'd1) : in_v[i];
      a_sq_nxt[i] = 47'(48'(m) * 48'(m));
    end
    b_rad_nxt[0] = {48'(a_sq_r[0]) + 48'(a_sq_r[1]) + 48'(a_sq_r[2]), 14'd0};
    b_rad_nxt[1] = {48'(a_sq_r[3]) + 48'(a_sq_r[4]) + 48'(a_sq_r[5]), 14'd0};
  end

  avq_isqrt #(.LANES(2), .IN_W(62), .SW(144)) u_len_in (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(b_val_r), .rad_i(b_rad_r),
    .side_i(b_v_r), .valid_o(l1_val), .root_o(l1_len), .side_o(l1_v)
  );

  always_comb begin
    logic [23:0] m;
    logic [30:0] ln;
    for (int i = 0; i < 6; i++) begin
      ln = (i < 3) ? l1_len[0] : l1_len[1];
      m  = l1_v[i][23] ? (~l1_v[i] + 24'd1) : l1_v[i];
      c_num_nxt[i] = {m, 37'd0} + 61'(ln >> 1);
      c_den_nxt[i] = ln;
      c_neg_nxt[i] = l1_v[i][23];
    end
    c_deg_nxt = (l1_len[0] == '0) || (l1_len[1] == '0);
  end

  avq_div #(.LANES(6), .NW(61), .DW(31), .QW(31), .SW(7)) u_unit (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(c_val_r), .num_i(c_num_r),
    .den_i(c_den_r), .side_i({c_deg_r, c_neg_r}), .valid_o(q1_val), .quo_o(q1),
    .side_o(q1_side)
  );

  always_comb begin
    logic [31:0] ms, mt;
    logic [32:0] hm;
    for (int i = 0; i < 3; i++) begin
      ms = 32'(q1[i]);
      mt = 32'(q1[i+3]);
      d_us_nxt[i] = q1_side[i] ? (32'd0 - ms) : ms;
      d_ut_nxt[i] = q1_side[i+3] ? (32'd0 - mt) : mt;
      d_h_nxt[i]  = 33'($signed(d_us_nxt[i])) + 33'($signed(d_ut_nxt[i]));
      hm = d_h_r[i][32] ? (33'd0 - d_h_r[i]) : d_h_r[i];
      e_sq_nxt[i] = 64'(hm[31:0]) * 64'(hm[31:0]);
    end
  end

  avq_isqrt #(.LANES(1), .IN_W(64), .SW(292)) u_len_h (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(f_val_r), .rad_i(f_rad_r),
    .side_i({f_deg_r, f_h_r, f_ut_r, f_us_r}), .valid_o(l2_val), .root_o(l2_len),
    .side_o(l2_side)
  );
  assign {l2_deg, l2_h, l2_ut, l2_us} = l2_side;

  always_comb begin
    logic [32:0] hm;
    for (int i = 0; i < 3; i++) begin
      hm = l2_h[i][32] ? (33'd0 - l2_h[i]) : l2_h[i];
      g_num_nxt[i]  = {hm[31:0], 30'd0} + 62'(l2_len[0] >> 1);
      g_hneg_nxt[i] = l2_h[i][32];
    end
  end

  avq_div #(.LANES(3), .NW(62), .DW(32), .QW(31), .SW(196)) u_unit_h (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(g_val_r), .num_i(g_num_r),
    .den_i(g_den_r), .side_i({g_deg_r, g_hneg_r, g_ut_r, g_us_r}), .valid_o(q2_val),
    .quo_o(q2), .side_o(q2_side)
  );
  assign {q2_deg, q2_hneg, q2_ut, q2_us} = q2_side;

  always_comb begin
    logic [2:0][31:0] hn;
    logic [31:0]      m;
    logic [32:0]      cm;
    for (int i = 0; i < 3; i++) begin
      m = 32'(q2[i]);
      hn[i] = q2_hneg[i] ? (32'd0 - m) : m;
      h_pd_nxt[i] = 64'($signed(q2_us[i])) * 64'($signed(hn[i]));
      cm = j_c_r[i][32] ? (33'd0 - j_c_r[i]) : j_c_r[i];
      k_csq_nxt[i] = 64'(cm) * 64'(cm);
      n_sp_nxt[i] = 64'($signed(m_ut_r[i])) * 64'($signed(m_d_r[i]));
    end
    h_pc_nxt[0] = 64'($signed(q2_us[1])) * 64'($signed(hn[2]));
    h_pc_nxt[1] = 64'($signed(q2_us[2])) * 64'($signed(hn[1]));
    h_pc_nxt[2] = 64'($signed(q2_us[2])) * 64'($signed(hn[0]));
    h_pc_nxt[3] = 64'($signed(q2_us[0])) * 64'($signed(hn[2]));
    h_pc_nxt[4] = 64'($signed(q2_us[0])) * 64'($signed(hn[1]));
    h_pc_nxt[5] = 64'($signed(q2_us[1])) * 64'($signed(hn[0]));
    k_dp_nxt[0] = 64'($signed(j_us_r[1])) * 64'($signed(j_c_r[2]));
    k_dp_nxt[1] = 64'($signed(j_us_r[2])) * 64'($signed(j_c_r[1]));
    k_dp_nxt[2] = 64'($signed(j_us_r[2])) * 64'($signed(j_c_r[0]));
    k_dp_nxt[3] = 64'($signed(j_us_r[0])) * 64'($signed(j_c_r[2]));
    k_dp_nxt[4] = 64'($signed(j_us_r[0])) * 64'($signed(j_c_r[1]));
    k_dp_nxt[5] = 64'($signed(j_us_r[1])) * 64'($signed(j_c_r[0]));
  end

  avq_isqrt #(.LANES(1), .IN_W(64), .SW(122)) u_sine (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(o_val_r), .rad_i(o_rad_r),
    .side_i({o_deg_r, o_neg_r, o_c_r, o_w_r}), .valid_o(l3_val), .root_o(l3_root),
    .side_o(l3_side)
  );
  assign {l3_deg, l3_neg, l3_c, l3_w} = l3_side;

  always_comb begin
    logic               deg;
    logic signed [63:0] cv;
    qout_t [2:0]        q;
    deg = l3_deg || (l3_root[0] < SIN_MIN_Q30);
    for (int i = 0; i < 3; i++) begin
      cv = 64'($signed(l3_c[i]));
      if (l3_neg) cv = -cv;
      q[i] = deg ? '0 : sat_q16(rnd_sh(cv, 14));
    end
    qw_nxt   = deg ? '0 : sat_q16(64'($signed(l3_w)));
    qx_nxt   = q[0];
    qy_nxt   = q[1];
    qz_nxt   = q[2];
    vres_nxt = !deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_val_r     <= 1'b0;
      b_val_r     <= 1'b0;
      c_val_r     <= 1'b0;
      d_val_r     <= 1'b0;
      e_val_r     <= 1'b0;
      f_val_r     <= 1'b0;
      g_val_r     <= 1'b0;
      h_val_r     <= 1'b0;
      i_val_r     <= 1'b0;
      j_val_r     <= 1'b0;
      k_val_r     <= 1'b0;
      l_val_r     <= 1'b0;
      m_val_r     <= 1'b0;
      n_val_r     <= 1'b0;
      o_val_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_val_r     <= in_valid;
      b_val_r     <= a_val_r;
      c_val_r     <= l1_val;
      d_val_r     <= q1_val;
      e_val_r     <= d_val_r;
      f_val_r     <= e_val_r;
      g_val_r     <= l2_val;
      h_val_r     <= q2_val;
      i_val_r     <= h_val_r;
      j_val_r     <= i_val_r;
      k_val_r     <= j_val_r;
      l_val_r     <= k_val_r;
      m_val_r     <= l_val_r;
      n_val_r     <= m_val_r;
      o_val_r     <= n_val_r;
      out_valid_r <= l3_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_v_r   <= in_v;
      a_sq_r  <= a_sq_nxt;
      b_v_r   <= a_v_r;
      b_rad_r <= b_rad_nxt;
      c_num_r <= c_num_nxt;
      c_den_r <= c_den_nxt;
      c_neg_r <= c_neg_nxt;
      c_deg_r <= c_deg_nxt;
      d_us_r  <= d_us_nxt;
      d_ut_r  <= d_ut_nxt;
      d_h_r   <= d_h_nxt;
      d_deg_r <= q1_side[6];
      e_us_r  <= d_us_r;
      e_ut_r  <= d_ut_r;
      e_h_r   <= d_h_r;
      e_sq_r  <= e_sq_nxt;
      e_deg_r <= d_deg_r;
      f_us_r  <= e_us_r;
      f_ut_r  <= e_ut_r;
      f_h_r   <= e_h_r;
      f_deg_r <= e_deg_r;
      f_rad_r[0] <= e_sq_r[0] + e_sq_r[1] + e_sq_r[2];
      g_us_r   <= l2_us;
      g_ut_r   <= l2_ut;
      g_num_r  <= g_num_nxt;
      g_den_r  <= {3{l2_len[0]}};
      g_hneg_r <= g_hneg_nxt;
      g_deg_r  <= l2_deg || (l2_len[0] == '0);
      h_us_r  <= q2_us;
      h_ut_r  <= q2_ut;
      h_pd_r  <= h_pd_nxt;
      h_pc_r  <= h_pc_nxt;
      h_deg_r <= q2_deg;
      i_us_r   <= h_us_r;
      i_ut_r   <= h_ut_r;
      i_deg_r  <= h_deg_r;
      i_wdot_r <= h_pd_r[0] + h_pd_r[1] + h_pd_r[2];
      i_cr_r[0] <= h_pc_r[0] - h_pc_r[1];
      i_cr_r[1] <= h_pc_r[2] - h_pc_r[3];
      i_cr_r[2] <= h_pc_r[4] - h_pc_r[5];
      j_us_r  <= i_us_r;
      j_ut_r  <= i_ut_r;
      j_deg_r <= i_deg_r;
      j_w_r   <= 21'(rnd_sh($signed(i_wdot_r), 44));
      for (int i = 0; i < 3; i++) begin
        j_c_r[i] <= 33'(rnd_sh($signed(i_cr_r[i]), 30));
        l_dr_r[i] <= k_dp_r[2*i] - k_dp_r[2*i+1];
        m_d_r[i] <= 34'(rnd_sh($signed(l_dr_r[i]), 30));
      end
      k_ut_r  <= j_ut_r;
      k_w_r   <= j_w_r;
      k_c_r   <= j_c_r;
      k_deg_r <= j_deg_r;
      k_csq_r <= k_csq_nxt;
      k_dp_r  <= k_dp_nxt;
      l_ut_r  <= k_ut_r;
      l_w_r   <= k_w_r;
      l_c_r   <= k_c_r;
      l_deg_r <= k_deg_r;
      l_rad_r <= k_csq_r[0] + k_csq_r[1] + k_csq_r[2];
      m_ut_r  <= l_ut_r;
      m_w_r   <= l_w_r;
      m_c_r   <= l_c_r;
      m_deg_r <= l_deg_r;
      m_rad_r <= l_rad_r;
      n_w_r   <= m_w_r;
      n_c_r   <= m_c_r;
      n_deg_r <= m_deg_r;
      n_rad_r <= m_rad_r;
      n_sp_r  <= n_sp_nxt;
      o_w_r   <= n_w_r;
      o_c_r   <= n_c_r;
      o_deg_r <= n_deg_r;
      o_rad_r[0] <= n_rad_r;
      o_neg_r <= $signed(n_sp_r[0] + n_sp_r[1] + n_sp_r[2]) > 64'sd0;
      qw_r    <= qw_nxt;
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      qz_r    <= qz_nxt;
      vres_r  <= vres_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quat_w    = qw_r;
  assign out_quat_x    = qx_r;
  assign out_quat_y    = qy_r;
  assign out_quat_z    = qz_r;
  assign out_valid_res = vres_r;

endmodule
